@@ sv/bmhq_pkg.sv @@
package bmhq_pkg;

  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned PAYLOAD_W = 12;
  localparam int unsigned FILL_W    = 13;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W   = ADDR_W + 2;
  localparam int unsigned ENTRY_W = KEY_BITS + PAYLOAD_W;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_LEFT,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } fsm_e;

  typedef struct packed {
    mode_e                mode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [FILL_W-1:0]    fill;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  function automatic logic [FILL_W-1:0] fill_of(logic [CNT_W-1:0] cnt);
    return FILL_W'(cnt);
  endfunction

endpackage

@@ sv/bmhq_ram.sv @@
module bmhq_ram #(
  parameter int unsigned Width = 28,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bmhq_core.sv @@
module bmhq_core import bmhq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  in_item_t  req_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o
);

  fsm_e               state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  entry_t             mov_q, mov_d;
  entry_t             top_q, top_d;
  entry_t             left_q, left_d;
  logic               rvalid_q, rvalid_d;
  mode_e              op_q, op_d;
  out_item_t          res_q, res_d;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  entry_t             wdata, rd;
  logic [ENTRY_W-1:0] rdata;

  logic [ADDR_W-1:0]  par_pos, grand_pos, pick_pos;
  logic [IDX_W-1:0]   lidx, ridx, nlidx;
  entry_t             pick;

  bmhq_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd = entry_t'(rdata);

  // heap index arithmetic
  assign par_pos   = (pos_q - ADDR_W'(1)) >> 1;
  assign grand_pos = (par_pos - ADDR_W'(1)) >> 1;
  assign lidx      = (IDX_W'(pos_q) << 1) + IDX_W'(1);
  assign ridx      = lidx + IDX_W'(1);

  // right child only wins when strictly smaller
  always_comb begin
    pick     = left_q;
    pick_pos = ADDR_W'(lidx);
    if (rvalid_q && (rd.key < left_q.key)) begin
      pick     = rd;
      pick_pos = ADDR_W'(ridx);
    end
  end

  assign nlidx = (IDX_W'(pick_pos) << 1) + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mov_q    <= mov_d;
    top_q    <= top_d;
    left_q   <= left_d;
    rvalid_q <= rvalid_d;
    op_q     <= op_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    mov_d       = mov_q;
    top_d       = top_q;
    left_d      = left_q;
    rvalid_d    = rvalid_q;
    op_d        = op_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = mov_q;
    re          = 1'b0;
    raddr       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d = req_i.mode;
          if (req_i.mode == MODE_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_d   = '{STATUS_FULL, '0, '0, fill_of(count_q)};
              state_d = S_DONE;
            end else begin
              mov_d   = '{KEY_BITS'(req_i.key), req_i.payload};
              pos_d   = ADDR_W'(count_q);
              count_d = count_q + CNT_W'(1);
              if (count_q == '0) begin
                state_d = S_PLACE;
              end else begin
                re      = 1'b1;
                raddr   = (ADDR_W'(count_q) - ADDR_W'(1)) >> 1;
                state_d = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_d   = '{STATUS_EMPTY, '0, '0, fill_of(count_q)};
              state_d = S_DONE;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              state_d = S_RM_ROOT;
            end
          end
        end
      end

      // parent word is on the read port
      S_UP: begin
        if (mov_q.key < rd.key) begin
          we    = 1'b1;
          waddr = pos_q;
          wdata = rd;
          pos_d = par_pos;
          if (par_pos != '0) begin
            re    = 1'b1;
            raddr = grand_pos;
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_RM_ROOT: begin
        top_d   = rd;
        re      = 1'b1;
        raddr   = ADDR_W'(count_q - CNT_W'(1));
        state_d = S_RM_LAST;
      end

      S_RM_LAST: begin
        mov_d   = rd;
        count_d = count_q - CNT_W'(1);
        pos_d   = '0;
        if (count_q > CNT_W'(2)) begin
          re      = 1'b1;
          raddr   = ADDR_W'(1);
          state_d = S_DN_LEFT;
        end else begin
          state_d = S_PLACE;
        end
      end

      // left child on the read port, fetch right if it exists
      S_DN_LEFT: begin
        left_d   = rd;
        rvalid_d = ridx < IDX_W'(count_q);
        if (ridx < IDX_W'(count_q)) begin
          re    = 1'b1;
          raddr = ADDR_W'(ridx);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (mov_q.key > pick.key) begin
          we    = 1'b1;
          waddr = pos_q;
          wdata = pick;
          pos_d = pick_pos;
          if (nlidx < IDX_W'(count_q)) begin
            re      = 1'b1;
            raddr   = ADDR_W'(nlidx);
            state_d = S_DN_LEFT;
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = mov_q;
        if (op_q == MODE_REMOVE) begin
          res_d = '{STATUS_DONE, KEY_W'(top_q.key), top_q.payload, fill_of(count_q)};
        end else begin
          res_d = '{STATUS_DONE, '0, '0, fill_of(count_q)};
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

@@ sv/binary_min_heap_queue.sv @@
// binary min-heap priority queue: insert (key, payload) or remove the entry with the smallest
// key; one result word per input word, with the fill level after the operation. entries live
// in a single ram with one read and one write port, so cost is set by ram reads on the sift
// path. an entry moves at most 12 levels on an insert and 11 on a remove at 4096 entries.
// empty removes and full inserts finish without a ram access. one word is worked on at a
// time; a finished result sits in the output register while the next word is accepted, and a
// result still held there stalls the core until it is taken. keys that tie never swap and an
// insert into a full heap is dropped with a full status.
module binary_min_heap_queue import bmhq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      res_valid, res_ready;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  bmhq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output slot frees as it is taken
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ verif/testbench.sv @@
module testbench import bmhq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam time     CLK_PERIOD   = 4ns;
  localparam int      RESET_CYCLES = 7;
  localparam int      MAX_IDLE     = 18;
  localparam int      STALL_LIMIT  = 600;
  localparam int      SETTLE       = 40;
  localparam int      PRINT_CAP    = 40;
  localparam int      BURSTS       = 13;
  localparam int      BURST_LEN    = 50;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // typed expectation travelling with the word currently offered
  bit        want_typed  = 1'b0;
  out_item_t want_word   = '0;

  entry_t      heap_mirror [CAPACITY];
  int unsigned mirror_count = 0;
  out_item_t   due_results [$];
  int unsigned err_count = 0;
  int unsigned sent_fill = 0;
  bit          calm = 1'b0;
  dir_row_t    dir_rows [$];

  binary_min_heap_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic out_item_t heap_outcome(in_item_t w);
    out_item_t   r;
    entry_t      moving;
    entry_t      top;
    int unsigned pos;
    int unsigned up;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    r = '0;
    if (w.mode == MODE_INSERT) begin
      if (mirror_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        moving.key     = KEY_BITS'(w.key);
        moving.payload = w.payload;
        pos = mirror_count;
        mirror_count++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (moving.key < heap_mirror[up].key) begin
            heap_mirror[pos] = heap_mirror[up];
            pos = up;
          end else begin
            break;
          end
        end
        heap_mirror[pos] = moving;
        r.status = STATUS_DONE;
      end
    end else if (mirror_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      top = heap_mirror[0];
      heap_mirror[0] = heap_mirror[mirror_count - 1];
      mirror_count--;
      if (mirror_count > 1) begin
        moving = heap_mirror[0];
        pos = 0;
        while (1'b1) begin
          left  = 2 * pos + 1;
          right = left + 1;
          if (left >= mirror_count) break;
          pick = left;
          // right child only when strictly smaller, so ties go left
          if (right < mirror_count && heap_mirror[right].key < heap_mirror[left].key) begin
            pick = right;
          end
          if (moving.key > heap_mirror[pick].key) begin
            heap_mirror[pos] = heap_mirror[pick];
            pos = pick;
          end else begin
            break;
          end
        end
        heap_mirror[pos] = moving;
      end
      r.status      = STATUS_DONE;
      r.out_key     = KEY_W'(top.key);
      r.out_payload = top.payload;
    end
    r.fill = FILL_W'(mirror_count);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_count < PRINT_CAP) begin
      $display("%0t mismatch on %0s: got %0h, want %0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  always @(posedge clk_i) begin : watch_words
    out_item_t guess;
    out_item_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        guess = heap_outcome(in_item_i);
        due_results = {due_results, (want_typed ? want_word : guess)};
      end
      if (out_valid_o && out_ready_i) begin
        seen = out_item_o;
        if (due_results.size() == 0) begin
          flag_mismatch("result word with nothing due", 32'(seen.out_key), 32'd0);
        end else begin
          guess = due_results.pop_front();
          if (seen.status !== guess.status)
            flag_mismatch("status", 32'(seen.status), 32'(guess.status));
          if (seen.out_key !== guess.out_key)
            flag_mismatch("out_key", 32'(seen.out_key), 32'(guess.out_key));
          if (seen.out_payload !== guess.out_payload)
            flag_mismatch("out_payload", 32'(seen.out_payload), 32'(guess.out_payload));
          if (seen.fill !== guess.fill)
            flag_mismatch("fill", 32'(seen.fill), 32'(guess.fill));
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $realtime, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    return calm ? 0 : $urandom_range(MAX_IDLE, 0);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(5, 0))
      0:       return KEY_W'($urandom_range(7, 0));
      1:       return $urandom_range(1, 0) ? '1 : '0;
      2:       return KEY_W'($urandom_range(40, 0));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // receiver: a freshly drawn stall, none when calm, ahead of every word
  initial begin : sink
    int stall;
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(input in_item_t word, input bit typed, input out_item_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= word;
    want_typed <= typed;
    want_word  <= want;
    do @(posedge clk_i); while (!in_ready_o);
    if (word.mode == MODE_INSERT) begin
      if (sent_fill < CAPACITY) sent_fill++;
    end else if (sent_fill > 0) begin
      sent_fill--;
    end
  endtask

  task automatic send_random(input mode_e m);
    in_item_t w;
    w.mode    = m;
    w.key     = pick_key();
    w.payload = PAYLOAD_W'($urandom_range(4095, 0));
    send_word(w, 1'b0, '0);
  endtask

  task automatic hold_off();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input mode_e m, input logic [KEY_W-1:0] k,
                         input logic [PAYLOAD_W-1:0] p, input bit typed,
                         input status_e st, input logic [KEY_W-1:0] ok,
                         input logic [PAYLOAD_W-1:0] op, input logic [FILL_W-1:0] fl);
    dir_row_t r;
    r.word  = '{mode: m, key: k, payload: p};
    r.typed = typed;
    r.want  = '{status: st, out_key: ok, out_payload: op, fill: fl};
    dir_rows = {dir_rows, r};
  endtask

  initial begin : stimulus
    int unsigned bias;
    // empty remove, both key extremes in and out, empty again
    add_row(MODE_REMOVE, 16'h1234, 12'h321, 1'b1, STATUS_EMPTY, '0, '0, 13'd0);
    add_row(MODE_INSERT, 16'hFFFF, 12'hFFF, 1'b1, STATUS_DONE, '0, '0, 13'd1);
    add_row(MODE_INSERT, 16'h0000, 12'h000, 1'b1, STATUS_DONE, '0, '0, 13'd2);
    add_row(MODE_REMOVE, 16'h0000, 12'h000, 1'b1, STATUS_DONE, 16'h0000, 12'h000, 13'd1);
    add_row(MODE_REMOVE, 16'hFFFF, 12'hFFF, 1'b1, STATUS_DONE, 16'hFFFF, 12'hFFF, 13'd0);
    add_row(MODE_REMOVE, 16'hFFFF, 12'hFFF, 1'b1, STATUS_EMPTY, '0, '0, 13'd0);
    // equal keys must keep their places
    add_row(MODE_INSERT, 16'd7, 12'h001, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd7, 12'h002, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd7, 12'h003, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd7, 12'h004, 1'b0, STATUS_DONE, '0, '0, '0);
    repeat (4) add_row(MODE_REMOVE, '0, '0, 1'b0, STATUS_DONE, '0, '0, '0);
    // mixed order, sift both ways
    add_row(MODE_INSERT, 16'd9, 12'hAAA, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd4, 12'h555, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd8, 12'h123, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd1, 12'h0F0, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_INSERT, 16'd6, 12'hF0F, 1'b0, STATUS_DONE, '0, '0, '0);
    repeat (5) add_row(MODE_REMOVE, 16'hA5A5, 12'h5A5, 1'b0, STATUS_DONE, '0, '0, '0);
    add_row(MODE_REMOVE, '0, '0, 1'b1, STATUS_EMPTY, '0, '0, 13'd0);
    add_row(MODE_INSERT, 16'h8000, 12'h800, 1'b1, STATUS_DONE, '0, '0, 13'd1);
    add_row(MODE_INSERT, 16'h7FFF, 12'h7FF, 1'b1, STATUS_DONE, '0, '0, 13'd2);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    hold_off();

    // bursts that lean towards filling or towards draining
    for (int b = 0; b < BURSTS; b++) begin
      bias = $urandom_range(90, 15);
      calm = ($urandom_range(3, 0) == 0);
      for (int i = 0; i < BURST_LEN; i++) begin
        send_random(($urandom_range(99, 0) < bias) ? MODE_INSERT : MODE_REMOVE);
      end
      if (b == BURSTS / 2) hold_off();
    end

    // drain what is left, then knock on the empty heap
    hold_off();
    calm = 1'b0;
    while (sent_fill > 0) send_random(MODE_REMOVE);
    repeat (2) send_random(MODE_REMOVE);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_core.sv
sv/binary_min_heap_queue.sv
verif/testbench.sv
